### sv/rand_index_contingency_top_assert.svh
// Assertion macros for the contingency block.
`ifndef RAND_INDEX_CONTINGENCY_TOP_ASSERT_SVH
`define RAND_INDEX_CONTINGENCY_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RIC_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RIC_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RIC_ASSERT_IMPL(label, clk, rst, prop, msg)
`define RIC_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

### sv/ric_pkg.sv
// ----------------------------------------------------------------------------
// ric_pkg
// Shared constants and status codes of the Rand index contingency block.
// ----------------------------------------------------------------------------
`default_nettype none
package ric_pkg;
   localparam int MaxSegLabels   = 64;
   localparam int MaxTruthLabels = 64;
   localparam int CountBitsDef   = 32;
   localparam int LabelBits      = 16;
   localparam int OutBits        = 62;
   localparam int RatioBits      = 17;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FEW      = 2'd1,
      STATUS_TABLE    = 2'd2,
      STATUS_SATURATE = 2'd3
   } status_type;
endpackage
`default_nettype wire

### sv/rand_index_contingency_top.sv
// ----------------------------------------------------------------------------
// rand_index_contingency_top
// Contingency table accumulator reporting the pair count, disagreements and
// Rand index of a segmentation against ground truth.
// ----------------------------------------------------------------------------
// A word is accepted on req_ when start is high and busy is low. Busy rises
// for the whole time the word is processed. A voxel first searches the
// segmentation and then the truth label table, one entry per cycle, so busy
// stays high longer as the tables fill; an ignored voxel skips the search
// and update and, if it is not last, goes back to idle through the wrap
// state. The cell, row and column counts live in memories and are updated
// by a read, modify and write sequence; one shared adder keeps the sums of
// their squares. On a last word the block computes N(N-1)/2 from 16 bit
// slices of N-1 and runs a restoring divider of 16 steps plus rounding (or
// reports zeros and STATUS_FEW when N < 2), then shows the result on rsp_
// for one cycle marked by rsp_valid; the receiver cannot stall it.
// Afterwards, and after reset, a clearing pass sweeps all cell counts, 4096
// at the default table sizes, one cell per cycle, while busy stays high.
// The csr_ channel writes the ignore label any time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rand_index_contingency_top_assert.svh"
module rand_index_contingency_top
   import ric_pkg::*;
#(
   parameter int MAX_SEG_LABELS   = MaxSegLabels,
   parameter int MAX_TRUTH_LABELS = MaxTruthLabels,
   parameter int COUNT_BITS       = CountBitsDef
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [LabelBits-1:0]  req_seg_label,
   input  wire logic [LabelBits-1:0]  req_truth_label,
   input  wire logic                  req_last_voxel,
   output logic                       rsp_valid,
   output logic [OutBits-1:0]         rsp_pair_total,
   output logic [OutBits-1:0]         rsp_disagreements,
   output logic [RatioBits-1:0]       rsp_rand_index,
   output logic [1:0]                 rsp_status,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [LabelBits-1:0]  csr_ignore_truth_label
);
   localparam int SB    = $clog2(MAX_SEG_LABELS);
   localparam int TB    = $clog2(MAX_TRUTH_LABELS);
   localparam int SU    = $clog2(MAX_SEG_LABELS + 1);
   localparam int TU    = $clog2(MAX_TRUTH_LABELS + 1);
   localparam int KB    = (SU > TU) ? SU : TU;
   localparam int CB    = SB + TB;
   localparam int CELLS = 1 << CB;
   localparam int CW    = COUNT_BITS;
   localparam logic [CW-1:0] CountMax = {CW{1'b1}};

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_SSRCH, ST_TSRCH, ST_CHECK, ST_RD, ST_CELL, ST_ROW,
      ST_COL, ST_WRAP, ST_FIN, ST_MUL0, ST_MUL1, ST_MUL2, ST_DIS0, ST_DIS1,
      ST_DIV, ST_RND, ST_OUT
   } state_type;

   state_type state_ff;
   logic [LabelBits-1:0] ignore_ff;
   logic [LabelBits-1:0] seg_mem [MAX_SEG_LABELS];
   logic [LabelBits-1:0] truth_mem [MAX_TRUTH_LABELS];
   logic [CW-1:0] cell_mem [CELLS];
   logic [CW-1:0] row_mem [MAX_SEG_LABELS];
   logic [CW-1:0] col_mem [MAX_TRUTH_LABELS];
   logic [MAX_SEG_LABELS-1:0]   row_vld_ff;
   logic [MAX_TRUTH_LABELS-1:0] col_vld_ff;
   logic [SU-1:0] seg_used_ff;
   logic [TU-1:0] truth_used_ff;
   logic [LabelBits-1:0] s_ff, t_ff;
   logic last_ff;
   logic [KB-1:0] k_ff;
   logic [SB-1:0] si_ff;
   logic [TB-1:0] ti_ff;
   logic s_hit_ff, t_hit_ff;
   logic [CB-1:0] clr_ff;
   logic [CW-1:0] cell_q_ff, row_q_ff, col_q_ff;
   logic [CW-1:0] n_ff;
   logic [63:0] sq_cell_ff, sq_row_ff, sq_col_ff;
   logic [1:0] err_ff;
   logic [63:0] acc_ff;   // pairs numerator / product
   logic [63:0] pairs_ff, dis_ff, rem_ff;
   logic [16:0] q_ff;
   logic [4:0] step_ff;
   logic [CW-1:0] nm1_ff;
   logic [63:0] pp_ff;
   logic [LabelBits-1:0] seg_rd_ff, truth_rd_ff;

   // Shared adder of the update sequence and the disagreement steps.
   logic [63:0] add_a, add_b, add_sum;
   assign add_sum = add_a + add_b;

   // The label tables are read one entry ahead of the compare.
   logic [SB-1:0] seg_raddr;
   logic [TB-1:0] truth_raddr;
   assign seg_raddr   = (state_ff == ST_SSRCH) ? k_ff[SB-1:0] + 1'b1 : '0;
   assign truth_raddr = (state_ff == ST_TSRCH) ? k_ff[TB-1:0] + 1'b1 : '0;

   logic insert_ok;
   assign insert_ok = !((!s_hit_ff && seg_used_ff == SU'(MAX_SEG_LABELS)) ||
                        (!t_hit_ff && truth_used_ff == TU'(MAX_TRUTH_LABELS))) &&
                      (n_ff != CountMax);

   logic [CB-1:0] cidx;
   assign cidx = {si_ff, ti_ff};

   logic [64:0] rem2;
   assign rem2 = {rem_ff, 1'b0};

   always_comb begin
      add_a = 64'd0;
      add_b = 64'd0;
      case (state_ff)
         ST_CELL: begin add_a = sq_cell_ff; add_b = 64'({cell_q_ff, 1'b1}); end
         ST_ROW:  begin add_a = sq_row_ff;  add_b = 64'({row_q_ff, 1'b1}); end
         ST_COL:  begin add_a = sq_col_ff;  add_b = 64'({col_q_ff, 1'b1}); end
         ST_DIS0: begin add_a = sq_row_ff;  add_b = ~sq_cell_ff + 64'd1; end
         ST_DIS1: begin add_a = sq_col_ff;  add_b = ~sq_cell_ff + 64'd1; end
         default: begin add_a = 64'd0; add_b = 64'd0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         ignore_ff <= csr_ignore_truth_label;
      end
   end
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         cell_mem[clr_ff] <= '0;
      end else if (state_ff == ST_CELL) begin
         cell_mem[cidx] <= cell_q_ff + 1'b1;
      end
      if (state_ff == ST_RD) begin
         cell_q_ff <= cell_mem[cidx];
         row_q_ff  <= row_vld_ff[si_ff] ? row_mem[si_ff] : '0;
         col_q_ff  <= col_vld_ff[ti_ff] ? col_mem[ti_ff] : '0;
      end
      seg_rd_ff   <= seg_mem[seg_raddr];
      truth_rd_ff <= truth_mem[truth_raddr];
      if (state_ff == ST_ROW) row_mem[si_ff] <= row_q_ff + 1'b1;
      if (state_ff == ST_COL) col_mem[ti_ff] <= col_q_ff + 1'b1;
      if (state_ff == ST_CHECK && insert_ok && !s_hit_ff)
         seg_mem[seg_used_ff[SB-1:0]] <= s_ff;
      if (state_ff == ST_CHECK && insert_ok && !t_hit_ff)
         truth_mem[truth_used_ff[TB-1:0]] <= t_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid <= 1'b0;
         seg_used_ff <= '0;
         truth_used_ff <= '0;
         row_vld_ff <= '0;
         col_vld_ff <= '0;
         n_ff <= '0;
         sq_cell_ff <= '0;
         sq_row_ff <= '0;
         sq_col_ff <= '0;
         err_ff <= '0;
      end else begin
         rsp_valid <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CB'(CELLS - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (start) begin
                  s_ff <= req_seg_label;
                  t_ff <= req_truth_label;
                  last_ff <= req_last_voxel;
                  k_ff <= '0;
                  s_hit_ff <= 1'b0;
                  t_hit_ff <= 1'b0;
                  if (req_truth_label == ignore_ff) state_ff <= ST_WRAP;
                  else state_ff <= ST_SSRCH;
               end
            end
            ST_SSRCH: begin
               if (k_ff == KB'(seg_used_ff) || s_hit_ff) begin
                  k_ff <= '0;
                  state_ff <= ST_TSRCH;
               end else if (seg_rd_ff == s_ff) begin
                  s_hit_ff <= 1'b1;
                  si_ff <= k_ff[SB-1:0];
               end else k_ff <= k_ff + 1'b1;
            end
            ST_TSRCH: begin
               if (k_ff == KB'(truth_used_ff) || t_hit_ff) state_ff <= ST_CHECK;
               else if (truth_rd_ff == t_ff) begin
                  t_hit_ff <= 1'b1;
                  ti_ff <= k_ff[TB-1:0];
               end else k_ff <= k_ff + 1'b1;
            end
            ST_CHECK: begin
               if ((!s_hit_ff && seg_used_ff == SU'(MAX_SEG_LABELS)) ||
                   (!t_hit_ff && truth_used_ff == TU'(MAX_TRUTH_LABELS))) begin
                  err_ff[0] <= 1'b1;
                  state_ff <= ST_WRAP;
               end else if (n_ff == CountMax) begin
                  err_ff[1] <= 1'b1;
                  state_ff <= ST_WRAP;
               end else begin
                  if (!s_hit_ff) begin
                     si_ff <= seg_used_ff[SB-1:0];
                     seg_used_ff <= seg_used_ff + 1'b1;
                  end
                  if (!t_hit_ff) begin
                     ti_ff <= truth_used_ff[TB-1:0];
                     truth_used_ff <= truth_used_ff + 1'b1;
                  end
                  state_ff <= ST_RD;
               end
            end
            ST_RD: state_ff <= ST_CELL;
            ST_CELL: begin sq_cell_ff <= add_sum; state_ff <= ST_ROW; end
            ST_ROW: begin
               sq_row_ff <= add_sum;
               row_vld_ff[si_ff] <= 1'b1;
               state_ff <= ST_COL;
            end
            ST_COL: begin
               sq_col_ff <= add_sum;
               col_vld_ff[ti_ff] <= 1'b1;
               n_ff <= n_ff + 1'b1;
               state_ff <= ST_WRAP;
            end
            ST_WRAP: state_ff <= last_ff ? ST_FIN : ST_IDLE;
            ST_FIN: begin
               nm1_ff <= n_ff - 1'b1;
               if (n_ff < CW'(2)) begin
                  rsp_pair_total <= '0;
                  rsp_disagreements <= '0;
                  rsp_rand_index <= '0;
                  rsp_status <= STATUS_FEW;
                  state_ff <= ST_OUT;
               end else state_ff <= ST_MUL0;
            end
            ST_MUL0: begin
               // Split product: low 16 bits of n times n-1, then the high half.
               pp_ff <= 64'(n_ff) * 64'(nm1_ff[15:0]);
               state_ff <= ST_MUL1;
            end
            ST_MUL1: begin
               acc_ff <= pp_ff;
               pp_ff <= 64'(n_ff) * 64'(nm1_ff >> 16);
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               pairs_ff <= (acc_ff + (pp_ff << 16)) >> 1;
               state_ff <= ST_DIS0;
            end
            ST_DIS0: begin dis_ff <= add_sum >> 1; state_ff <= ST_DIS1; end
            ST_DIS1: begin
               if (dis_ff + (add_sum >> 1) > pairs_ff) dis_ff <= pairs_ff;
               else dis_ff <= dis_ff + (add_sum >> 1);
               rem_ff <= '0;
               q_ff <= '0;
               step_ff <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (step_ff == 5'd0) begin
                  rem_ff <= pairs_ff - dis_ff;
                  if (dis_ff == 64'd0) begin
                     q_ff <= 17'd65536;
                     state_ff <= ST_RND;
                     step_ff <= 5'd31;
                  end else step_ff <= 5'd1;
               end else if (step_ff == 5'd17) begin
                  if (rem2 >= {1'b0, pairs_ff}) q_ff <= q_ff + 1'b1;
                  state_ff <= ST_RND;
               end else begin
                  q_ff <= {q_ff[15:0], rem2 >= {1'b0, pairs_ff}};
                  rem_ff <= (rem2 >= {1'b0, pairs_ff}) ?
                            64'(rem2 - {1'b0, pairs_ff}) : rem2[63:0];
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_RND: begin
               rsp_pair_total <= pairs_ff[OutBits-1:0];
               rsp_disagreements <= dis_ff[OutBits-1:0];
               rsp_rand_index <= q_ff;
               if (err_ff[0]) rsp_status <= STATUS_TABLE;
               else if (err_ff[1] || pairs_ff[63:62] != 2'b00) rsp_status <= STATUS_SATURATE;
               else rsp_status <= STATUS_OK;
               if (pairs_ff[63:62] != 2'b00) rsp_pair_total <= '1;
               if (dis_ff[63:62] != 2'b00) rsp_disagreements <= '1;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               rsp_valid <= 1'b1;
               seg_used_ff <= '0;
               truth_used_ff <= '0;
               row_vld_ff <= '0;
               col_vld_ff <= '0;
               n_ff <= '0;
               sq_cell_ff <= '0;
               sq_row_ff <= '0;
               sq_col_ff <= '0;
               err_ff <= '0;
               clr_ff <= '0;
               state_ff <= ST_CLEAR;
            end
            default: state_ff <= ST_CLEAR;
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);

   `RIC_ASSERT_IMPL(a_rsp_busy, clock, reset, rsp_valid |-> $past(busy), "result without work")
   `RIC_ASSERT_IMPL(a_rsp_pulse, clock, reset, rsp_valid |=> !rsp_valid, "result longer than a cycle")
   `RIC_ASSERT_NORST(a_reset_clear, clock, reset |=> busy && !rsp_valid, "reset must start clearing")
endmodule
`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Rand index contingency testbench
// Feeds voxel words (a segmentation and a truth label each) to the block and
// checks every result against a behavioral contingency-table predictor.
// A short directed table comes first, then label table overflow runs and random images of varied shape.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import ric_pkg::*;

   typedef struct packed {
      logic [OutBits-1:0]   pairs;
      logic [OutBits-1:0]   disagree;
      logic [RatioBits-1:0] ratio;
      status_type           status;
   } score_type;

   typedef struct {
      logic [15:0] seg;
      logic [15:0] truth;
      logic        last;
      logic        known;
      score_type   score;
   } voxel_row_type;

   logic clock, reset, start, busy, rsp_valid, csr_valid, csr_ready;
   logic [15:0] req_seg_label, req_truth_label, csr_ignore_truth_label;
   logic req_last_voxel;
   logic [OutBits-1:0] rsp_pair_total, rsp_disagreements;
   logic [RatioBits-1:0] rsp_rand_index;
   logic [1:0] rsp_status;

   rand_index_contingency_top dut (.*);

   // predictor state
   logic [15:0] ignore_label;
   logic [15:0] seg_tab[MaxSegLabels];
   logic [15:0] truth_tab[MaxTruthLabels];
   int unsigned seg_used, truth_used;
   logic [31:0] cell_cnt[MaxSegLabels][MaxTruthLabels];
   logic [31:0] row_cnt[MaxSegLabels], col_cnt[MaxTruthLabels];
   logic [31:0] voxels;
   logic [63:0] sq_cells, sq_rows, sq_cols;
   logic [1:0]  flags;

   score_type expected_scores[$];
   int mismatches, score_count, voxel_count, config_count;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic void clear_tables();
      seg_used = 0;
      truth_used = 0;
      voxels = 0;
      sq_cells = 0;
      sq_rows = 0;
      sq_cols = 0;
      flags = 0;
      foreach (row_cnt[i]) row_cnt[i] = 0;
      foreach (col_cnt[i]) col_cnt[i] = 0;
      foreach (cell_cnt[i, j]) cell_cnt[i][j] = 0;
   endfunction

   function automatic logic [16:0] q16_of(logic [63:0] num, logic [63:0] den);
      logic [64:0] r;
      logic [16:0] q;
      r = {1'b0, num};
      q = '0;
      if (num >= den) return 17'd65536;
      for (int b = 0; b < 16; b++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
         end
      end
      if ((r << 1) >= den) q = q + 1'b1;
      return q;
   endfunction

   function automatic void tally_voxel(logic [15:0] s, logic [15:0] t);
      int si, ti;
      logic [63:0] c;
      si = -1;
      ti = -1;
      for (int k = 0; k < seg_used; k++) if (seg_tab[k] == s && si < 0) si = k;
      for (int k = 0; k < truth_used; k++) if (truth_tab[k] == t && ti < 0) ti = k;
      if ((si < 0 && seg_used >= MaxSegLabels) || (ti < 0 && truth_used >= MaxTruthLabels)) begin
         flags[0] = 1'b1;
         return;
      end
      if (voxels == 32'hFFFF_FFFF) begin
         flags[1] = 1'b1;
         return;
      end
      if (si < 0) begin
         si = seg_used++;
         seg_tab[si] = s;
      end
      if (ti < 0) begin
         ti = truth_used++;
         truth_tab[ti] = t;
      end
      c = 64'(cell_cnt[si][ti]);
      sq_cells += 2 * c + 1;
      cell_cnt[si][ti] = 32'(c + 1);
      c = 64'(row_cnt[si]);
      sq_rows += 2 * c + 1;
      row_cnt[si] = 32'(c + 1);
      c = 64'(col_cnt[ti]);
      sq_cols += 2 * c + 1;
      col_cnt[ti] = 32'(c + 1);
      voxels++;
   endfunction

   function automatic void queue_score(score_type sc);
      expected_scores = {expected_scores, sc};
   endfunction

   function automatic void predict_voxel(logic [15:0] s, logic [15:0] t, logic last);
      logic [63:0] n, pairs, dis;
      logic [63:0] lim;
      logic clamp;
      score_type sc;
      if (t != ignore_label) tally_voxel(s, t);
      if (!last) return;
      lim = (64'd1 << 62) - 1;
      n = 64'(voxels);
      clamp = 0;
      sc = '0;
      if (n < 2) begin
         sc.status = STATUS_FEW;
      end else begin
         pairs = (n * (n - 1)) >> 1;
         dis = ((sq_rows - sq_cells) >> 1) + ((sq_cols - sq_cells) >> 1);
         if (dis > pairs) dis = pairs;
         sc.ratio = q16_of(pairs - dis, pairs);
         if (pairs > lim) begin pairs = lim; clamp = 1; end
         if (dis > lim) begin dis = lim; clamp = 1; end
         sc.pairs = pairs[OutBits-1:0];
         sc.disagree = dis[OutBits-1:0];
         if (flags[0]) sc.status = STATUS_TABLE;
         else if (flags[1] || clamp) sc.status = STATUS_SATURATE;
         else sc.status = STATUS_OK;
      end
      queue_score(sc);
      clear_tables();
   endfunction

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
          ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
      repeat (n) @(negedge clock);
   endtask

   task automatic send_voxel(logic [15:0] s, logic [15:0] t, logic last);
      req_seg_label = s;
      req_truth_label = t;
      req_last_voxel = last;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_voxel(s, t, last);
      voxel_count++;
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic write_ignore(logic [15:0] v);
      wait (expected_scores.size() == 0);
      repeat (300) @(negedge clock);
      while (busy) @(negedge clock);
      csr_ignore_truth_label = v;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      ignore_label = v;
      config_count++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_scores.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word");
         end else begin
            score_type e;
            e = expected_scores.pop_front();
            score_count++;
            if (rsp_pair_total !== e.pairs || rsp_disagreements !== e.disagree ||
                rsp_rand_index !== e.ratio || rsp_status !== e.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                     e.pairs, e.disagree, e.ratio, e.status, rsp_pair_total,
                     rsp_disagreements, rsp_rand_index, rsp_status);
            end
         end
      end
   end

   // random image: well-formed runs of few labels, some noisy or ignored
   task automatic send_image(int len, int nseg, int ntruth);
      logic [15:0] base_s, base_t, s, t;
      base_s = 16'($urandom);
      base_t = 16'($urandom);
      for (int i = 0; i < len; i++) begin
         s = 16'(base_s + $urandom_range(0, nseg - 1));
         t = 16'(base_t + $urandom_range(0, ntruth - 1));
         if ($urandom_range(0, 9) == 0) t = ignore_label;
         if ($urandom_range(0, 49) == 0) s = 16'($urandom);
         send_voxel(s, t, i == len - 1);
         idle_gap();
      end
   endtask

   voxel_row_type directed[$];

   function automatic void add_row(logic [15:0] s, logic [15:0] t, logic last,
                                   logic known = 0, score_type sc = '0);
      voxel_row_type r;
      r.seg = s;
      r.truth = t;
      r.last = last;
      r.known = known;
      r.score = sc;
      directed = {directed, r};
   endfunction

   initial begin
      score_type few;
      start = 0;
      req_seg_label = 0;
      req_truth_label = 0;
      req_last_voxel = 0;
      csr_valid = 0;
      csr_ignore_truth_label = 0;
      reset = 1;
      mismatches = 0;
      ignore_label = 0;
      clear_tables();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      few = '0;
      few.status = STATUS_FEW;
      add_row(16'h1234, 16'h0001, 1, 1, few);
      add_row(16'h0000, 16'h0000, 1, 1, few);
      add_row(16'hFFFF, 16'hFFFF, 0);
      add_row(16'h0000, 16'hFFFF, 0);
      add_row(16'hFFFF, 16'h0001, 0);
      add_row(16'h0000, 16'h0001, 1);
      add_row(16'h00AA, 16'h5555, 0);
      add_row(16'h00AA, 16'h5555, 0);
      add_row(16'h00AA, 16'h5555, 1);
      add_row(16'h0001, 16'h0002, 0);
      add_row(16'h0003, 16'h0002, 0);
      add_row(16'h0003, 16'h0000, 0);
      add_row(16'h0004, 16'h0007, 1);
      foreach (directed[i]) begin
         send_voxel(directed[i].seg, directed[i].truth, directed[i].last);
         if (directed[i].known && directed[i].last)
            expected_scores[expected_scores.size() - 1] = directed[i].score;
      end

      write_ignore(16'hFFFF);
      send_image(8, 2, 2);
      send_voxel(16'h0007, 16'hFFFF, 1);
      // overflow the segmentation label table, then the truth label table
      for (int i = 0; i < 70; i++) send_voxel(16'(16'h8000 + i), 16'h0003, i == 69);
      for (int i = 0; i < 70; i++) send_voxel(16'h0003, 16'(16'h4000 + i), i == 69);

      for (int p = 0; p < 4; p++) begin
         write_ignore(p == 3 ? 16'h0000 : 16'($urandom));
         while (voxel_count < 230 + p * 230) begin
            send_image($urandom_range(1, 25), $urandom_range(1, 6),
                       $urandom_range(1, 6));
            if ($urandom_range(0, 15) == 0) repeat ($urandom_range(20, 60)) @(negedge clock);
         end
      end

      wait (expected_scores.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d voxels, %0d results, %0d ignore label settings",
         voxel_count, score_count, config_count);
      if (mismatches == 0 && expected_scores.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
